/* rtl/rre_pkg.sv */
`default_nettype none

package rre_pkg;

  localparam int unsigned CoordW   = 9;
  localparam int unsigned CharW    = 8;
  localparam int unsigned PosW     = 24;
  localparam int unsigned SizeW    = 23;
  localparam int unsigned FracW    = 8;
  localparam int unsigned SpanW    = PosW + 1 - FracW;
  localparam int unsigned ReadW    = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CeilOff  = (1 << FracW) - 1;

  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned CmdDepth     = 2;
  localparam int unsigned ResDepth     = 2;

  localparam logic [CoordW-1:0] WidthRst  = 9'd256;
  localparam logic [CoordW-1:0] HeightRst = 9'd256;
  localparam logic [CharW-1:0]  BgRst     = 8'd32;

  typedef enum logic [KindW-1:0] {
    KindClear = 2'd0,
    KindDraw  = 2'd1,
    KindRead  = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgBg     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OpFill,
    OpReadMem,
    OpReadBg
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StPaint,
    StRead
  } state_e;

  typedef struct packed {
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
    logic [CharW-1:0]  bg;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic              outline;
    logic              at_top;
    logic              at_bottom;
    logic              at_left;
    logic              at_right;
    logic [CoordW-1:0] row_lo;
    logic [CoordW-1:0] row_hi;
    logic [CoordW-1:0] col_lo;
    logic [CoordW-1:0] col_hi;
    logic [CharW-1:0]  chr;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/rre_fifo.sv */
`default_nettype none

module rre_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    wrap_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wrap_inc(wptr_q) : wptr_q;
    rptr_d = do_pop ? wrap_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/rre_front.sv */
`default_nettype none

module rre_front #(
  parameter int unsigned MaxWidth  = rre_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = rre_pkg::MaxHeightDef
) (
  input  rre_pkg::cfg_t                      cfg_i,
  input  logic        [rre_pkg::KindW-1:0]   kind_i,
  input  logic                               outline_only_i,
  input  logic signed [rre_pkg::PosW-1:0]    rect_x_i,
  input  logic signed [rre_pkg::PosW-1:0]    rect_y_i,
  input  logic        [rre_pkg::SizeW-1:0]   rect_width_i,
  input  logic        [rre_pkg::SizeW-1:0]   rect_height_i,
  input  logic        [rre_pkg::CharW-1:0]   paint_char_i,
  input  logic        [rre_pkg::ReadW-1:0]   read_row_i,
  input  logic        [rre_pkg::ReadW-1:0]   read_col_i,
  output rre_pkg::cmd_t                      cmd_o,
  output logic                               keep_o
);

  typedef struct packed {
    logic                       hit;
    logic                       lo_edge;
    logic                       hi_edge;
    logic [rre_pkg::CoordW-1:0] lo;
    logic [rre_pkg::CoordW-1:0] hi;
  } span_t;

  logic [rre_pkg::CoordW-1:0] eff_w;
  logic [rre_pkg::CoordW-1:0] eff_h;
  logic                       read_in;
  span_t                      sx;
  span_t                      sy;

  // Ceiling of the start, floor of the end, then clipping to [0, lim - 1].
  function automatic span_t clip_span(input logic signed [rre_pkg::PosW-1:0]  pos,
                                      input logic        [rre_pkg::SizeW-1:0] len,
                                      input logic        [rre_pkg::CoordW-1:0] lim);
    logic signed [rre_pkg::PosW:0]    start_sum;
    logic signed [rre_pkg::PosW:0]    end_sum;
    logic signed [rre_pkg::SpanW-1:0] first;
    logic signed [rre_pkg::SpanW-1:0] last;
    logic signed [rre_pkg::SpanW-1:0] lim_m1;
    logic signed [rre_pkg::SpanW-1:0] lo;
    logic signed [rre_pkg::SpanW-1:0] hi;
    span_t                            s;
    start_sum = $signed({pos[rre_pkg::PosW-1], pos})
              + $signed((rre_pkg::PosW + 1)'(rre_pkg::CeilOff));
    end_sum   = $signed({pos[rre_pkg::PosW-1], pos}) + $signed((rre_pkg::PosW + 1)'(len));
    first     = start_sum[rre_pkg::PosW:rre_pkg::FracW];
    last      = end_sum[rre_pkg::PosW:rre_pkg::FracW];
    lim_m1    = $signed(rre_pkg::SpanW'(lim) - rre_pkg::SpanW'(1));
    s.lo_edge = !first[rre_pkg::SpanW-1];
    s.hi_edge = (last <= lim_m1);
    lo        = s.lo_edge ? first : '0;
    hi        = s.hi_edge ? last : lim_m1;
    s.hit     = (lo <= hi) && (len != '0);
    s.lo      = lo[rre_pkg::CoordW-1:0];
    s.hi      = hi[rre_pkg::CoordW-1:0];
    clip_span = s;
  endfunction

  assign eff_w = (32'(cfg_i.width) > 32'(MaxWidth)) ?
                 rre_pkg::CoordW'(MaxWidth) : cfg_i.width;
  assign eff_h = (32'(cfg_i.height) > 32'(MaxHeight)) ?
                 rre_pkg::CoordW'(MaxHeight) : cfg_i.height;

  assign sx      = clip_span(rect_x_i, rect_width_i, eff_w);
  assign sy      = clip_span(rect_y_i, rect_height_i, eff_h);
  assign read_in = (rre_pkg::CoordW'(read_row_i) < eff_h) &&
                   (rre_pkg::CoordW'(read_col_i) < eff_w);

  always_comb begin
    cmd_o  = '0;
    keep_o = 1'b0;
    case (kind_i)
      rre_pkg::KindClear: begin
        cmd_o.op     = rre_pkg::OpFill;
        cmd_o.row_hi = eff_h - 1'b1;
        cmd_o.col_hi = eff_w - 1'b1;
        cmd_o.chr    = cfg_i.bg;
        keep_o       = (eff_w != '0) && (eff_h != '0);
      end
      rre_pkg::KindDraw: begin
        cmd_o.op        = rre_pkg::OpFill;
        cmd_o.outline   = outline_only_i;
        cmd_o.at_top    = sy.lo_edge;
        cmd_o.at_bottom = sy.hi_edge;
        cmd_o.at_left   = sx.lo_edge;
        cmd_o.at_right  = sx.hi_edge;
        cmd_o.row_lo    = sy.lo;
        cmd_o.row_hi    = sy.hi;
        cmd_o.col_lo    = sx.lo;
        cmd_o.col_hi    = sx.hi;
        cmd_o.chr       = paint_char_i;
        keep_o          = sx.hit && sy.hit;
      end
      rre_pkg::KindRead: begin
        cmd_o.op     = read_in ? rre_pkg::OpReadMem : rre_pkg::OpReadBg;
        cmd_o.row_lo = rre_pkg::CoordW'(read_row_i);
        cmd_o.col_lo = rre_pkg::CoordW'(read_col_i);
        cmd_o.chr    = cfg_i.bg;
        keep_o       = 1'b1;
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rre_back.sv */
`default_nettype none

module rre_back #(
  parameter int unsigned MaxWidth  = rre_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = rre_pkg::MaxHeightDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rre_pkg::cmd_t              cmd_i,
  input  logic                       cmd_empty_i,
  output logic                       cmd_pop_o,
  input  logic                       res_full_i,
  output logic                       res_push_o,
  output logic [rre_pkg::CharW-1:0]  res_data_o
);

  localparam int unsigned ColAw = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned RowAw = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int unsigned AddrW = RowAw + ColAw;

  rre_pkg::state_e            state_q, state_d;
  rre_pkg::cmd_t              cur_q;
  logic                       load_cur;
  logic [rre_pkg::CoordW-1:0] row_q, row_d;
  logic [rre_pkg::CoordW-1:0] col_q, col_d;
  logic [rre_pkg::CharW-1:0]  frame_q [2**AddrW];
  logic [rre_pkg::CharW-1:0]  rdata_q;
  logic                       mem_we;
  logic                       mem_re;
  logic [AddrW-1:0]           waddr;
  logic [AddrW-1:0]           raddr;
  logic                       last_px;
  logic                       paint_px;

  assign waddr = {RowAw'(row_q), ColAw'(col_q)};
  assign raddr = {RowAw'(cmd_i.row_lo), ColAw'(cmd_i.col_lo)};

  assign last_px  = (row_q == cur_q.row_hi) && (col_q == cur_q.col_hi);
  assign paint_px = !cur_q.outline
                 || (cur_q.at_top    && (row_q == cur_q.row_lo))
                 || (cur_q.at_bottom && (row_q == cur_q.row_hi))
                 || (cur_q.at_left   && (col_q == cur_q.col_lo))
                 || (cur_q.at_right  && (col_q == cur_q.col_hi));

  always_comb begin
    state_d = state_q;
    case (state_q)
      rre_pkg::StIdle: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            rre_pkg::OpFill: begin
              state_d = rre_pkg::StPaint;
            end
            rre_pkg::OpReadMem: begin
              if (!res_full_i) begin
                state_d = rre_pkg::StRead;
              end
            end
            default: begin
              state_d = rre_pkg::StIdle;
            end
          endcase
        end
      end
      rre_pkg::StPaint: begin
        if (last_px) begin
          state_d = rre_pkg::StIdle;
        end
      end
      rre_pkg::StRead: begin
        state_d = rre_pkg::StIdle;
      end
      default: begin
        state_d = rre_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    load_cur   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    res_push_o = 1'b0;
    res_data_o = rdata_q;
    row_d      = row_q;
    col_d      = col_q;
    case (state_q)
      rre_pkg::StIdle: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            rre_pkg::OpFill: begin
              cmd_pop_o = 1'b1;
              load_cur  = 1'b1;
              row_d     = cmd_i.row_lo;
              col_d     = cmd_i.col_lo;
            end
            rre_pkg::OpReadMem: begin
              if (!res_full_i) begin
                cmd_pop_o = 1'b1;
                mem_re    = 1'b1;
              end
            end
            rre_pkg::OpReadBg: begin
              if (!res_full_i) begin
                cmd_pop_o  = 1'b1;
                res_push_o = 1'b1;
                res_data_o = cmd_i.chr;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      rre_pkg::StPaint: begin
        mem_we = paint_px;
        if (last_px) begin
          row_d = '0;
          col_d = '0;
        end else if (col_q == cur_q.col_hi) begin
          row_d = row_q + 1'b1;
          col_d = cur_q.col_lo;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      rre_pkg::StRead: begin
        res_push_o = 1'b1;
      end
      default: begin
        row_d = '0;
        col_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rre_pkg::StIdle;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cur) begin
      cur_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_q[waddr] <= cur_q.chr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= frame_q[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rectangle_raster_engine_unit.sv */
// Channel   Direction  Handshake          Payload
// command   in         push / full        kind_i, outline_only_i, rect_*_i, paint_char_i,
//                                         read_row_i, read_col_i
// result    out        empty / pop        pixel_char_o
// config    in         cfg_we_i           cfg_addr_i, cfg_wdata_i
//
// A clear or draw is loaded in the idle state and then walks its clipped box pixel by
// pixel, since the frame store has a single write port. A read inside the canvas loads
// the frame store into a register and is pushed to the result queue from the read state;
// a read outside the canvas pushes the background character straight from the idle state.
// Commands that paint nothing and unused kinds are dropped on arrival and never queued.
// Reset empties both queues; the frame store is not cleared and holds garbage until a
// clear command has run. A full result queue stalls reads and all commands behind them.
`default_nettype none

module rectangle_raster_engine_unit #(
  parameter int unsigned MaxWidth  = rre_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = rre_pkg::MaxHeightDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic        [rre_pkg::KindW-1:0]   kind_i,
  input  logic                               outline_only_i,
  input  logic signed [rre_pkg::PosW-1:0]    rect_x_i,
  input  logic signed [rre_pkg::PosW-1:0]    rect_y_i,
  input  logic        [rre_pkg::SizeW-1:0]   rect_width_i,
  input  logic        [rre_pkg::SizeW-1:0]   rect_height_i,
  input  logic        [rre_pkg::CharW-1:0]   paint_char_i,
  input  logic        [rre_pkg::ReadW-1:0]   read_row_i,
  input  logic        [rre_pkg::ReadW-1:0]   read_col_i,
  output logic                               empty,
  input  logic                               pop,
  output logic        [rre_pkg::CharW-1:0]   pixel_char_o,
  input  logic                               cfg_we_i,
  input  logic        [rre_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic        [rre_pkg::CfgDataW-1:0] cfg_wdata_i
);

  rre_pkg::cfg_t             cfg_q, cfg_d;
  rre_pkg::cmd_t             front_cmd;
  rre_pkg::cmd_t             head_cmd;
  logic                      front_keep;
  logic                      cmd_push;
  logic                      cmd_pop;
  logic                      cmd_empty;
  logic                      res_push;
  logic                      res_full;
  logic [rre_pkg::CharW-1:0] res_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        rre_pkg::CfgWidth: begin
          cfg_d.width = cfg_wdata_i;
        end
        rre_pkg::CfgHeight: begin
          cfg_d.height = cfg_wdata_i;
        end
        rre_pkg::CfgBg: begin
          cfg_d.bg = cfg_wdata_i[rre_pkg::CharW-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= rre_pkg::WidthRst;
      cfg_q.height <= rre_pkg::HeightRst;
      cfg_q.bg     <= rre_pkg::BgRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cmd_push = push && !full && front_keep;

  rre_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .cfg_i          (cfg_q),
    .kind_i         (kind_i),
    .outline_only_i (outline_only_i),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .paint_char_i   (paint_char_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .cmd_o          (front_cmd),
    .keep_o         (front_keep)
  );

  rre_fifo #(
    .Width ($bits(rre_pkg::cmd_t)),
    .Depth (rre_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (front_cmd),
    .pop_i   (cmd_pop),
    .full_o  (full),
    .empty_o (cmd_empty),
    .rdata_o (head_cmd)
  );

  rre_back #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_data)
  );

  rre_fifo #(
    .Width (rre_pkg::CharW),
    .Depth (rre_pkg::ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_data),
    .pop_i   (pop),
    .full_o  (res_full),
    .empty_o (empty),
    .rdata_o (pixel_char_o)
  );

endmodule

`default_nettype wire

/* rtl/rre_checker.sv */
`default_nettype none

module rre_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [rre_pkg::CharW-1:0] pixel_char_o
);

  // When reset is sampled low, the result queue must read empty at the following sample.
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result offered after reset");

  // When reset is sampled low, the command queue must be open at the following sample.
  a_open_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("command queue full after reset");

  // A waiting result that is not taken stays and keeps its value.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_char_o)))
    else $error("waiting result dropped or changed");

endmodule

bind rectangle_raster_engine_unit rre_checker u_rre_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .pixel_char_o (pixel_char_o)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam logic [rre_pkg::KindW-1:0]   KindUnused = 2'd3;
  localparam logic [rre_pkg::CfgIdxW-1:0] CfgUnused  = 2'd3;
  localparam logic [rre_pkg::CharW-1:0]   CharR      = "R";
  localparam int                 CycleLimit = 3000000;
  localparam int                 SettleCycles = 20;

  typedef struct {
    logic [rre_pkg::KindW-1:0]        kind;
    logic                             outline;
    logic signed [rre_pkg::PosW-1:0]  x;
    logic signed [rre_pkg::PosW-1:0]  y;
    logic [rre_pkg::SizeW-1:0]        w;
    logic [rre_pkg::SizeW-1:0]        h;
    logic [rre_pkg::CharW-1:0]        chr;
    logic [rre_pkg::ReadW-1:0]        row;
    logic [rre_pkg::ReadW-1:0]        col;
  } raster_cmd_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              push = 1'b0;
  logic                              full;
  logic [rre_pkg::KindW-1:0]         kind_i = '0;
  logic                              outline_only_i = 1'b0;
  logic signed [rre_pkg::PosW-1:0]   rect_x_i = '0;
  logic signed [rre_pkg::PosW-1:0]   rect_y_i = '0;
  logic [rre_pkg::SizeW-1:0]         rect_width_i = '0;
  logic [rre_pkg::SizeW-1:0]         rect_height_i = '0;
  logic [rre_pkg::CharW-1:0]         paint_char_i = '0;
  logic [rre_pkg::ReadW-1:0]         read_row_i = '0;
  logic [rre_pkg::ReadW-1:0]         read_col_i = '0;
  logic                              empty;
  logic                              pop = 1'b0;
  logic [rre_pkg::CharW-1:0]         pixel_char_o;
  logic                              cfg_we_i = 1'b0;
  logic [rre_pkg::CfgIdxW-1:0]       cfg_addr_i = '0;
  logic [rre_pkg::CfgDataW-1:0]      cfg_wdata_i = '0;

  // Shadow copy of the frame store and registers.
  logic [rre_pkg::CharW-1:0]  frame_px [rre_pkg::MaxHeightDef][rre_pkg::MaxWidthDef];
  logic [rre_pkg::CoordW-1:0] reg_width = rre_pkg::WidthRst;
  logic [rre_pkg::CoordW-1:0] reg_height = rre_pkg::HeightRst;
  logic [rre_pkg::CharW-1:0]  reg_bg = rre_pkg::BgRst;

  raster_cmd_t               pending_cmds [$];
  raster_cmd_t               cmd_on_port;
  logic [rre_pkg::CharW-1:0] expected_pixels [$];
  logic [rre_pkg::CharW-1:0] want;
  int                        issued_total = 0;
  int                        accepted_total = 0;
  int                        reads_checked = 0;
  int                        kind_count [4] = '{0, 0, 0, 0};
  int                        error_count = 0;
  int                        cycle_count = 0;
  int                        burst_left = 1;
  int                        gap_left = 0;
  logic [15:0]               stall_tick = '0;

  rectangle_raster_engine_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .outline_only_i (outline_only_i),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .paint_char_i   (paint_char_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_char_o   (pixel_char_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int canvas_cols();
    return (reg_width > rre_pkg::MaxWidthDef) ? int'(rre_pkg::MaxWidthDef) : int'(reg_width);
  endfunction

  function automatic int canvas_rows();
    return (reg_height > rre_pkg::MaxHeightDef) ? int'(rre_pkg::MaxHeightDef) :
                                                  int'(reg_height);
  endfunction

  function automatic void predict_command(input raster_cmd_t cmd);
    longint x0, x1, y0, y1, rlo, rhi, clo, chi, rr, cc;
    kind_count[cmd.kind]++;
    case (cmd.kind)
      rre_pkg::KindClear: begin
        for (rr = 0; rr < canvas_rows(); rr++)
          for (cc = 0; cc < canvas_cols(); cc++)
            frame_px[rr][cc] = reg_bg;
      end
      rre_pkg::KindDraw: begin
        if (cmd.w != '0 && cmd.h != '0) begin
          x0 = (longint'(cmd.x) + longint'(rre_pkg::CeilOff)) >>> rre_pkg::FracW;
          y0 = (longint'(cmd.y) + longint'(rre_pkg::CeilOff)) >>> rre_pkg::FracW;
          x1 = (longint'(cmd.x) + longint'(cmd.w)) >>> rre_pkg::FracW;
          y1 = (longint'(cmd.y) + longint'(cmd.h)) >>> rre_pkg::FracW;
          rlo = (y0 < 0) ? 0 : y0;
          clo = (x0 < 0) ? 0 : x0;
          rhi = (y1 < canvas_rows() - 1) ? y1 : longint'(canvas_rows() - 1);
          chi = (x1 < canvas_cols() - 1) ? x1 : longint'(canvas_cols() - 1);
          for (rr = rlo; rr <= rhi; rr++)
            for (cc = clo; cc <= chi; cc++)
              if (!cmd.outline || rr == y0 || rr == y1 || cc == x0 || cc == x1)
                frame_px[rr][cc] = cmd.chr;
        end
      end
      rre_pkg::KindRead: begin
        if (int'(cmd.row) < canvas_rows() && int'(cmd.col) < canvas_cols())
          expected_pixels.push_back(frame_px[cmd.row][cmd.col]);
        else
          expected_pixels.push_back(reg_bg);
      end
      default: ;
    endcase
  endfunction

  function automatic raster_cmd_t make_cmd(input logic [rre_pkg::KindW-1:0] kind);
    raster_cmd_t cmd;
    cmd.kind    = kind;
    cmd.outline = 1'($urandom_range(0, 1));
    cmd.x       = rre_pkg::PosW'($urandom());
    cmd.y       = rre_pkg::PosW'($urandom());
    cmd.w       = rre_pkg::SizeW'($urandom());
    cmd.h       = rre_pkg::SizeW'($urandom());
    cmd.chr     = rre_pkg::CharW'($urandom());
    cmd.row     = rre_pkg::ReadW'($urandom());
    cmd.col     = rre_pkg::ReadW'($urandom());
    return cmd;
  endfunction

  function automatic raster_cmd_t make_draw(input logic outline,
                                            input logic signed [rre_pkg::PosW-1:0] x,
                                            input logic signed [rre_pkg::PosW-1:0] y,
                                            input logic [rre_pkg::SizeW-1:0] w,
                                            input logic [rre_pkg::SizeW-1:0] h,
                                            input logic [rre_pkg::CharW-1:0] chr);
    raster_cmd_t cmd;
    cmd = make_cmd(rre_pkg::KindDraw);
    cmd.outline = outline;
    cmd.x = x;
    cmd.y = y;
    cmd.w = w;
    cmd.h = h;
    cmd.chr = chr;
    return cmd;
  endfunction

  function automatic raster_cmd_t make_read(input logic [rre_pkg::ReadW-1:0] row,
                                            input logic [rre_pkg::ReadW-1:0] col);
    raster_cmd_t cmd;
    cmd = make_cmd(rre_pkg::KindRead);
    cmd.row = row;
    cmd.col = col;
    return cmd;
  endfunction

  // Draws stay mostly small and near the canvas so that most of them clip or paint
  // something; a few use fully random fields.
  function automatic raster_cmd_t random_cmd(input int cols, input int rows);
    raster_cmd_t cmd;
    int pick, mode, xv, yv, span_c, span_r;
    pick = $urandom_range(0, 19);
    cmd = make_cmd(rre_pkg::KindRead);
    if (pick == 0 && cols * rows <= 4096) begin
      cmd.kind = rre_pkg::KindClear;
    end else if (pick == 1) begin
      cmd.kind = KindUnused;
    end else if (pick < 10) begin
      cmd.kind = rre_pkg::KindDraw;
      mode = $urandom_range(0, 9);
      if (mode != 0) begin
        span_c = (cols < 22) ? cols + 2 : 24;
        span_r = (rows < 22) ? rows + 2 : 24;
        xv = int'($urandom_range(0, (cols + 8) * 256)) - 1024;
        yv = int'($urandom_range(0, (rows + 8) * 256)) - 1024;
        cmd.x = xv[rre_pkg::PosW-1:0];
        cmd.y = yv[rre_pkg::PosW-1:0];
        cmd.w = rre_pkg::SizeW'($urandom_range(0, span_c * 256));
        cmd.h = rre_pkg::SizeW'($urandom_range(0, span_r * 256));
        if (mode == 1) begin
          if ($urandom_range(0, 1) == 1)
            cmd.w = '0;
          else
            cmd.h = '0;
        end
      end
    end else if (cols > 0 && rows > 0 && $urandom_range(0, 9) < 7) begin
      cmd.row = rre_pkg::ReadW'($urandom_range(0, rows - 1));
      cmd.col = rre_pkg::ReadW'($urandom_range(0, cols - 1));
    end
    return cmd;
  endfunction

  task automatic queue_cmd(input raster_cmd_t cmd);
    pending_cmds.push_back(cmd);
    issued_total++;
  endtask

  task automatic drain();
    while (accepted_total != issued_total || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rre_pkg::CfgIdxW-1:0] idx,
                           input logic [rre_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      rre_pkg::CfgWidth:  reg_width = val;
      rre_pkg::CfgHeight: reg_height = val;
      rre_pkg::CfgBg:     reg_bg = val[rre_pkg::CharW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_canvas(input logic [rre_pkg::CfgDataW-1:0] w,
                            input logic [rre_pkg::CfgDataW-1:0] h,
                            input logic [rre_pkg::CharW-1:0] bg);
    write_reg(rre_pkg::CfgWidth, w);
    write_reg(rre_pkg::CfgHeight, h);
    write_reg(rre_pkg::CfgBg, {1'b0, bg});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Every phase starts with a clear so that no read can hit a pixel that was never
  // written, and ends with a read so that the block is idle once it returns.
  task automatic run_phase(input logic [rre_pkg::CfgDataW-1:0] w,
                           input logic [rre_pkg::CfgDataW-1:0] h,
                           input logic [rre_pkg::CharW-1:0] bg, input int n_random);
    set_canvas(w, h, bg);
    queue_cmd(make_cmd(rre_pkg::KindClear));
    repeat (n_random) queue_cmd(random_cmd(canvas_cols(), canvas_rows()));
    queue_cmd(make_read(8'd0, 8'd0));
    drain();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_command(cmd_on_port);
        accepted_total++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_on_port = pending_cmds.pop_front();
          kind_i         <= cmd_on_port.kind;
          outline_only_i <= cmd_on_port.outline;
          rect_x_i       <= cmd_on_port.x;
          rect_y_i       <= cmd_on_port.y;
          rect_width_i   <= cmd_on_port.w;
          rect_height_i  <= cmd_on_port.h;
          paint_char_i   <= cmd_on_port.chr;
          read_row_i     <= cmd_on_port.row;
          read_col_i     <= cmd_on_port.col;
          push           <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 7))
              0, 1:    gap_left = 0;
              7:       gap_left = $urandom_range(20, 60);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          error_count++;
          $display("%0t: unrequested read result: expected none, got %0d",
                   $time, pixel_char_o);
        end else begin
          want = expected_pixels.pop_front();
          reads_checked++;
          if (pixel_char_o !== want) begin
            error_count++;
            $display("%0t: pixel_char mismatch: expected %0d, got %0d",
                     $time, want, pixel_char_o);
          end
        end
      end
      stall_tick <= stall_tick + 16'd1;
      case (stall_tick[7:6])
        2'd0:    pop <= 1'b1;
        2'd1:    pop <= ($urandom_range(0, 1) == 1);
        2'd2:    pop <= (stall_tick[1:0] == 2'd0);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_cmd(make_cmd(rre_pkg::KindClear));
    queue_cmd(make_read(8'd0, 8'd0));
    queue_cmd(make_read(8'd255, 8'd255));
    queue_cmd(make_draw(1'b0, 24'sd0, 24'sd0, 23'h7FFFFF, 23'h7FFFFF, 8'hFF));
    queue_cmd(make_read(8'd128, 8'd77));
    queue_cmd(make_draw(1'b1, 24'sh000180, 24'sh000240, 23'h000A80, 23'h000600, CharR));
    queue_cmd(make_read(8'd3, 8'd2));
    queue_cmd(make_read(8'd4, 8'd5));
    queue_cmd(make_read(8'd8, 8'd12));
    queue_cmd(make_draw(1'b0, 24'sh800000, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF, 8'h00));
    queue_cmd(make_draw(1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 8'h00));
    queue_cmd(make_draw(1'b0, 24'sd0, 24'sd0, 23'h000000, 23'h000500, 8'h00));
    queue_cmd(make_draw(1'b0, 24'sd0, 24'sd0, 23'h000500, 23'h000000, 8'h00));
    queue_cmd(make_draw(1'b1, -24'sd640, 24'sh000080, 23'h0003C0, 23'h000300, 8'h41));
    queue_cmd(make_read(8'd1, 8'd0));
    queue_cmd(make_read(8'd2, 8'd0));
    queue_cmd(make_read(8'd2, 8'd1));
    queue_cmd(make_read(8'd3, 8'd0));
    queue_cmd(make_draw(1'b0, 24'sh000010, 24'sd0, 23'h000020, 23'h000400, 8'h00));
    queue_cmd(make_cmd(KindUnused));
    queue_cmd(make_draw(1'b1, 24'sd0, 24'sd0, 23'h00FF00, 23'h00FF00, 8'h00));
    queue_cmd(make_read(8'd0, 8'd100));
    queue_cmd(make_read(8'd100, 8'd100));
    queue_cmd(make_read(8'd255, 8'd7));
    repeat (6) queue_cmd(random_cmd(canvas_cols(), canvas_rows()));
    queue_cmd(make_read(8'd0, 8'd0));
    drain();

    run_phase(9'd1, 9'd1, 8'd0, 8);
    write_reg(CfgUnused, 9'h1FF);
    run_phase(9'd0, 9'd5, 8'd255, 6);
    run_phase(9'd300, 9'd17, CharR, 8);
    run_phase(9'd511, 9'd40, 8'($urandom()), 8);
    run_phase(9'd7, 9'd256, 8'($urandom()), 8);
    run_phase(9'd256, 9'd1, 8'($urandom()), 6);
    run_phase(9'($urandom_range(1, 48)), 9'($urandom_range(1, 48)), 8'($urandom()), 9);

    $display("Ran %0d commands over 8 canvas settings: %0d clears, %0d draws, %0d reads,",
             accepted_total, kind_count[rre_pkg::KindClear], kind_count[rre_pkg::KindDraw],
             kind_count[rre_pkg::KindRead]);
    $display("%0d unused kinds; %0d read results checked.", kind_count[KindUnused],
             reads_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* rectangle_raster_engine_unit.f */
rtl/rre_pkg.sv
rtl/rre_fifo.sv
rtl/rre_front.sv
rtl/rre_back.sv
rtl/rectangle_raster_engine_unit.sv
rtl/rre_checker.sv
tb/testbench.sv
